/* src/assert_macros.svh */
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/uff_pkg.sv */
// Package with the types, codes and constants of the UART ring buffer core.
package uff_pkg;

    // Default ring depths.
    localparam int RX_DEPTH_DEF = 128;
    localparam int TX_DEPTH_DEF = 32;

    // Fixed widths of the transaction fields.
    localparam int MODE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int RX_FILL_W = 7;
    localparam int TX_ROOM_W = 5;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Item kinds.
    localparam logic [MODE_W-1:0] MODE_RX_BYTE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LINE_RDY = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XON     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF    = 2'd2;

    // Reset values of the flow control characters.
    localparam logic [BYTE_W-1:0] XON_RESET  = 8'd17;
    localparam logic [BYTE_W-1:0] XOFF_RESET = 8'd19;

    // Software flow control phase.
    typedef enum logic [1:0] {
        PH_XON_SENT  = 2'd0,
        PH_XOFF_SENT = 2'd1,
        PH_XON_PEND  = 2'd2
    } t_phase;

    // Input transaction.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data_byte;
        logic              overrun_flag;
        logic              framing_flag;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic                 read_valid;
        logic [BYTE_W-1:0]    read_byte;
        logic                 line_valid;
        logic [BYTE_W-1:0]    line_byte;
        logic                 write_accepted;
        logic [RX_FILL_W-1:0] rx_fill;
        logic [TX_ROOM_W-1:0] tx_room;
        logic [CNT_W-1:0]     dropped_total;
        logic [CNT_W-1:0]     overrun_total;
        logic [CNT_W-1:0]     framing_total;
        logic [RX_FILL_W-1:0] peak_fill;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // Saturating increment of an error counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

/* src/uff_ctrl.sv */
// Controller state machine that sequences one transaction through the datapath.
module uff_ctrl
    import uff_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The memories have delivered their data; commit once the result slot is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/uff_dp.sv */
// Datapath with the two rings, counters, flow control phase and result register.
module uff_dp
    import uff_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_in                  i_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_out                 o_out
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int XOFF_LVL = RX_DEPTH / 8;
    localparam int XON_LVL  = RX_DEPTH / 10;

    // Storage.
    logic [BYTE_W-1:0] r_rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] r_tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0] r_rx_q, r_tx_q;

    // Held transaction and configuration.
    t_in               r_item;
    logic              r_flow_en;
    logic [BYTE_W-1:0] r_xon, r_xoff;

    // Ring and status state.
    logic [RX_AW-1:0] r_rx_wr_pos, n_rx_wr_pos, r_rx_rd_pos, n_rx_rd_pos;
    logic [RX_AW-1:0] r_rx_level, n_rx_level, r_peak, n_peak;
    logic [TX_AW-1:0] r_tx_wr_pos, n_tx_wr_pos, r_tx_rd_pos, n_tx_rd_pos;
    logic [TX_AW-1:0] r_tx_room, n_tx_room;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_drop, n_drop, r_ovr, n_ovr, r_fe, n_fe;
    t_out             r_out, n_out;
    logic             rx_we, tx_we;
    logic             rx_full, rx_empty, tx_full, tx_empty;

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        rx_next = (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        tx_next = (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rx_full  = (r_rx_level == RX_AW'(RX_DEPTH - 1));
    assign rx_empty = (r_rx_level == '0);
    assign tx_full  = (r_tx_room == '0);
    assign tx_empty = (r_tx_room == TX_AW'(TX_DEPTH - 1));

    // Work out the effect of the held transaction.
    always_comb begin
        n_rx_wr_pos = r_rx_wr_pos;
        n_rx_rd_pos = r_rx_rd_pos;
        n_rx_level  = r_rx_level;
        n_peak      = r_peak;
        n_tx_wr_pos = r_tx_wr_pos;
        n_tx_rd_pos = r_tx_rd_pos;
        n_tx_room   = r_tx_room;
        n_phase     = r_phase;
        n_drop      = r_drop;
        n_ovr       = r_ovr;
        n_fe        = r_fe;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        n_out       = '0;
        unique case (r_item.mode)
            MODE_RX_BYTE: begin
                if (r_item.overrun_flag) begin
                    n_drop = sat_inc(r_drop);
                    n_ovr  = sat_inc(r_ovr);
                end
                if (r_item.framing_flag) begin
                    n_fe = sat_inc(r_fe);
                end
                if (!rx_full) begin
                    rx_we       = 1'b1;
                    n_rx_wr_pos = rx_next(r_rx_wr_pos);
                    n_rx_level  = r_rx_level + 1'b1;
                end else begin
                    n_drop = sat_inc(n_drop);
                end
                if (n_rx_level > r_peak) begin
                    n_peak = n_rx_level;
                end
                // XOFF goes straight out when the fill crosses one eighth.
                if (r_flow_en && r_phase != PH_XOFF_SENT &&
                    n_rx_level >= RX_AW'(XOFF_LVL)) begin
                    n_phase         = PH_XOFF_SENT;
                    n_out.line_valid = 1'b1;
                    n_out.line_byte  = r_xoff;
                end
            end
            MODE_READ, MODE_PEEK: begin
                if (!rx_empty) begin
                    n_out.read_valid = 1'b1;
                    n_out.read_byte  = r_rx_q;
                    if (r_item.mode == MODE_READ) begin
                        n_rx_rd_pos = rx_next(r_rx_rd_pos);
                        n_rx_level  = r_rx_level - 1'b1;
                        if (r_flow_en && r_phase == PH_XOFF_SENT &&
                            n_rx_level < RX_AW'(XON_LVL)) begin
                            n_phase = PH_XON_PEND;
                        end
                    end
                end
            end
            MODE_FLUSH: begin
                n_rx_rd_pos = r_rx_wr_pos;
                n_rx_level  = '0;
                if (r_flow_en && r_phase == PH_XOFF_SENT) begin
                    n_phase = PH_XON_PEND;
                end
            end
            MODE_WRITE: begin
                if (!tx_full) begin
                    tx_we                = 1'b1;
                    n_tx_wr_pos          = tx_next(r_tx_wr_pos);
                    n_tx_room            = r_tx_room - 1'b1;
                    n_out.write_accepted = 1'b1;
                end
            end
            MODE_LINE_RDY: begin
                // A pending XON leaves ahead of queued data.
                if (r_flow_en && r_phase == PH_XON_PEND) begin
                    n_out.line_valid = 1'b1;
                    n_out.line_byte  = r_xon;
                    n_phase          = PH_XON_SENT;
                end else if (!tx_empty) begin
                    n_out.line_valid = 1'b1;
                    n_out.line_byte  = r_tx_q;
                    n_tx_rd_pos      = tx_next(r_tx_rd_pos);
                    n_tx_room        = r_tx_room + 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_out.rx_fill       = RX_FILL_W'(n_rx_level);
        n_out.tx_room       = TX_ROOM_W'(n_tx_room);
        n_out.dropped_total = n_drop;
        n_out.overrun_total = n_ovr;
        n_out.framing_total = n_fe;
        n_out.peak_fill     = RX_FILL_W'(n_peak);
    end

    // Ring memories with registered reads at the read positions.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rx_we) begin
            r_rx_mem[r_rx_wr_pos] <= r_item.data_byte;
        end
        r_rx_q <= r_rx_mem[r_rx_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && tx_we) begin
            r_tx_mem[r_tx_wr_pos] <= r_item.data_byte;
        end
        r_tx_q <= r_tx_mem[r_tx_rd_pos];
    end

    // Held transaction and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    // Control state, counters and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr_pos <= '0;
            r_rx_rd_pos <= '0;
            r_rx_level  <= '0;
            r_peak      <= '0;
            r_tx_wr_pos <= '0;
            r_tx_rd_pos <= '0;
            r_tx_room   <= TX_AW'(TX_DEPTH - 1);
            r_phase     <= PH_XON_SENT;
            r_drop      <= '0;
            r_ovr       <= '0;
            r_fe        <= '0;
            r_flow_en   <= 1'b0;
            r_xon       <= XON_RESET;
            r_xoff      <= XOFF_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_rx_wr_pos <= n_rx_wr_pos;
                r_rx_rd_pos <= n_rx_rd_pos;
                r_rx_level  <= n_rx_level;
                r_peak      <= n_peak;
                r_tx_wr_pos <= n_tx_wr_pos;
                r_tx_rd_pos <= n_tx_rd_pos;
                r_tx_room   <= n_tx_room;
                r_phase     <= n_phase;
                r_drop      <= n_drop;
                r_ovr       <= n_ovr;
                r_fe        <= n_fe;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FLOW_EN: r_flow_en <= i_cfg_data[0];
                    CFG_XON:     r_xon     <= i_cfg_data;
                    CFG_XOFF:    r_xoff    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out = r_out;

endmodule

/* src/uart_fifo_xon_xoff_core.sv */
// Top level of the UART ring buffer core with XON/XOFF flow control.
// The core takes one transaction at a time on the input channel: a received
// byte, a host read or peek, a receive flush, a host write or a line-ready tick.
// Every input transaction yields exactly one result transaction that carries
// the read byte, the byte for the transmitter, the write status and the ring
// and error counter status after the step.
// An input transaction accepted in the idle state is held in the item register
// and executed once the result slot is free; the result then shows on the
// output. The core takes no new transaction until the last one has executed,
// and the execute state uses the registered read of the ring memories at their read positions.
// While a result waits, the core still accepts the next transaction, but that
// transaction is held until the waiting result is taken, so a stalled receiver
// stops the core after one more transaction.
// The configuration channel is always ready and writes flow enable, XON and
// XOFF codes; the user must use it only while the core is idle, which the core itself does not enforce.
// Synchronous reset empties both rings, clears counters and peak fill, marks
// XON as sent and restores the register defaults. No clearing pass is needed.
`include "assert_macros.svh"

module uart_fifo_xon_xoff_core
    import uff_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cmd cmd;

    // Sequencer.
    uff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Rings, counters and result register.
    uff_dp #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

    // The configuration channel is always ready.
    assign o_cfg_ready = 1'b1;

    // An accepted transaction keeps the input closed while it executes.
    `ASSERT_PROP(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input taken while executing")

    // A result never carries both a read byte and a line byte.
    `ASSERT_NEVER(a_read_line_excl, i_clk, i_rst_n, o_out_valid && o_out.read_valid && o_out.line_valid, "read and line byte in one result")

    // A write result carries neither a read byte nor a line byte.
    `ASSERT_NEVER(a_write_excl, i_clk, i_rst_n, o_out_valid && o_out.write_accepted && (o_out.read_valid || o_out.line_valid), "write result with other payload")

endmodule
